// ===== design/cube_face_to_sphere_point_core_macros.svh =====
// assertion macros for the cube face to sphere point core
// used by the checker module; no other dependencies
`ifndef CUBE_FACE_TO_SPHERE_POINT_CORE_MACROS_SVH
`define CUBE_FACE_TO_SPHERE_POINT_CORE_MACROS_SVH

// implication checked on every rising edge outside reset
`define CFSP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cfsp implication check failed");

// invariant checked on every rising edge outside reset
`define CFSP_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("cfsp invariant check failed");

`endif

// ===== design/cfsp_pkg.sv =====
// shared widths, constants and types for the cube face to sphere point core
// no dependencies
package cfsp_pkg;

    localparam int FRAC_W    = 30;
    localparam int COORD_W   = 32;
    localparam int MAG_W     = FRAC_W + 1;
    localparam int FACE_W    = 3;
    localparam int LEVEL_W   = 5;
    localparam int CHUNK_W   = 16;
    localparam int GRID_W    = 9;
    localparam int CS_W      = 9;
    localparam int MAX_LEVEL = 16;
    localparam int MAX_CHUNK = 256;
    localparam int CS_RESET  = 32;
    localparam int DEN_W     = 25;
    localparam int QUO_W     = FRAC_W + 2;
    localparam int AXES      = 3;
    localparam int UV        = 2;

    localparam int DIV_PER_STAGE  = 4;
    localparam int DIV_STAGES     = (QUO_W + DIV_PER_STAGE - 1) / DIV_PER_STAGE;
    localparam int ROOT_W         = MAG_W;
    localparam int RAD_W          = 2 * ROOT_W;
    localparam int SQRT_PER_STAGE = 4;
    localparam int SQRT_STAGES    = (ROOT_W + SQRT_PER_STAGE - 1) / SQRT_PER_STAGE;

    localparam int SIX_W       = FRAC_W + 4;
    localparam int Y_W         = 32;
    localparam int PROD_W      = 2 * Y_W;
    localparam int RECIP_SHIFT = 33;
    localparam logic [Y_W-1:0] RECIP_3 = 32'hAAAA_AAAB;

    localparam int LATENCY = 2 + DIV_STAGES + 6 + SQRT_STAGES + 2;

    localparam logic [FACE_W-1:0] FACE_FRONT  = 3'd0;
    localparam logic [FACE_W-1:0] FACE_BACK   = 3'd1;
    localparam logic [FACE_W-1:0] FACE_TOP    = 3'd2;
    localparam logic [FACE_W-1:0] FACE_BOTTOM = 3'd3;
    localparam logic [FACE_W-1:0] FACE_RIGHT  = 3'd4;
    localparam logic [FACE_W-1:0] FACE_LEFT   = 3'd5;

    typedef struct packed {
        logic                        bad;
        logic [AXES-1:0]             neg;
        logic [AXES-1:0][MAG_W-1:0]  mag;
    } point_tag_t;

endpackage

// ===== design/cube_face_to_sphere_point_core.sv =====
// cube face grid point to unit sphere point, signed q2.30 results
// pipeline: 26 stages from the register that accepts start to the register that strobes done
// throughput: one transaction per cycle, busy stays low; set by the fully pipelined
// 8-stage divider and 8-stage square root units
// reset: asynchronous active-low rst_n clears all valid bits, chunk_size returns to 32
// depends on cfsp_pkg, cfsp_div, cfsp_sqrt
module cube_face_to_sphere_point_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cfsp_pkg::CS_W-1:0]         chunk_size,
    input  logic [cfsp_pkg::FACE_W-1:0]       face,
    input  logic [cfsp_pkg::LEVEL_W-1:0]      level,
    input  logic [cfsp_pkg::CHUNK_W-1:0]      chunk_col,
    input  logic [cfsp_pkg::CHUNK_W-1:0]      chunk_row,
    input  logic [cfsp_pkg::GRID_W-1:0]       grid_col,
    input  logic [cfsp_pkg::GRID_W-1:0]       grid_row,
    output logic                              done,
    output logic signed [cfsp_pkg::COORD_W-1:0] sphere_x,
    output logic signed [cfsp_pkg::COORD_W-1:0] sphere_y,
    output logic signed [cfsp_pkg::COORD_W-1:0] sphere_z
);

    localparam int AX   = cfsp_pkg::AXES;
    localparam int MW   = cfsp_pkg::MAG_W;
    localparam int CW   = cfsp_pkg::COORD_W;
    localparam int PW2  = 2 * MW;
    localparam int QW1  = cfsp_pkg::QUO_W + 1;
    localparam logic [CW-1:0]  FX_ONE   = CW'(1) << cfsp_pkg::FRAC_W;
    localparam logic [PW2-1:0] RND_HALF = PW2'(1) << (cfsp_pkg::FRAC_W - 1);

    function automatic logic [MW-1:0] fx_mul(input logic [MW-1:0] a, input logic [MW-1:0] b);
        logic [PW2-1:0] p;
        p = PW2'(a) * PW2'(b) + RND_HALF;
        return MW'(p >> cfsp_pkg::FRAC_W);
    endfunction

    logic [cfsp_pkg::CS_W-1:0] chunk_size_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_size_reg <= cfsp_pkg::CS_W'(cfsp_pkg::CS_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            chunk_size_reg <= chunk_size;
        end
    end

    // stage a: register the transaction with clamped size and level
    logic [cfsp_pkg::CS_W-1:0]    cs_sat;
    logic [cfsp_pkg::LEVEL_W-1:0] lvl_sat;

    always_comb
    begin
        priority if (chunk_size_reg == '0)
            cs_sat = cfsp_pkg::CS_W'(1);
        else if (chunk_size_reg > cfsp_pkg::CS_W'(cfsp_pkg::MAX_CHUNK))
            cs_sat = cfsp_pkg::CS_W'(cfsp_pkg::MAX_CHUNK);
        else
            cs_sat = chunk_size_reg;
        if (level > cfsp_pkg::LEVEL_W'(cfsp_pkg::MAX_LEVEL))
            lvl_sat = cfsp_pkg::LEVEL_W'(cfsp_pkg::MAX_LEVEL);
        else
            lvl_sat = level;
    end

    logic                          a_vld_reg;
    logic [cfsp_pkg::FACE_W-1:0]   a_face_reg;
    logic [cfsp_pkg::LEVEL_W-1:0]  a_lvl_reg;
    logic [cfsp_pkg::CS_W-1:0]     a_cs_reg;
    logic [cfsp_pkg::CHUNK_W-1:0]  a_cc_reg;
    logic [cfsp_pkg::CHUNK_W-1:0]  a_cr_reg;
    logic [cfsp_pkg::GRID_W-1:0]   a_gc_reg;
    logic [cfsp_pkg::GRID_W-1:0]   a_gr_reg;

    always_ff @(posedge clk)
    begin
        a_face_reg <= face;
        a_lvl_reg  <= lvl_sat;
        a_cs_reg   <= cs_sat;
        a_cc_reg   <= chunk_col;
        a_cr_reg   <= chunk_row;
        a_gc_reg   <= grid_col;
        a_gr_reg   <= grid_row;
    end

    // stage b: numerators and denominator
    logic [cfsp_pkg::DEN_W-1:0] den_next;
    logic [cfsp_pkg::DEN_W-1:0] nu_full;
    logic [cfsp_pkg::DEN_W-1:0] nv_full;

    always_comb
    begin
        den_next = cfsp_pkg::DEN_W'(a_cs_reg) << a_lvl_reg;
        nu_full  = cfsp_pkg::DEN_W'(a_cc_reg) * cfsp_pkg::DEN_W'(a_cs_reg)
                 + cfsp_pkg::DEN_W'(a_gc_reg);
        nv_full  = cfsp_pkg::DEN_W'(a_cr_reg) * cfsp_pkg::DEN_W'(a_cs_reg)
                 + cfsp_pkg::DEN_W'(a_gr_reg);
    end

    logic                                           b_vld_reg;
    logic [cfsp_pkg::FACE_W-1:0]                    b_face_reg;
    logic [cfsp_pkg::DEN_W-1:0]                     b_den_reg;
    logic [cfsp_pkg::UV-1:0][cfsp_pkg::DEN_W-1:0]   b_num_reg;

    always_ff @(posedge clk)
    begin
        b_face_reg   <= a_face_reg;
        b_den_reg    <= den_next;
        b_num_reg[0] <= (nu_full > den_next) ? den_next : nu_full;
        b_num_reg[1] <= (nv_full > den_next) ? den_next : nv_full;
    end

    logic                                           dq_vld;
    logic [cfsp_pkg::UV-1:0][cfsp_pkg::QUO_W-1:0]   dq_quo;
    logic [cfsp_pkg::FACE_W-1:0]                    dq_face;

    cfsp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (b_vld_reg),
        .in_num    (b_num_reg),
        .in_den    (b_den_reg),
        .in_face   (b_face_reg),
        .out_valid (dq_vld),
        .out_quo   (dq_quo),
        .out_face  (dq_face)
    );

    // stage c: face coordinates and placement on the face
    logic [AX-1:0][CW-1:0] c_p_next;
    logic                  c_bad_next;

    always_comb
    begin
        logic [QW1-1:0] hu;
        logic [QW1-1:0] hv;
        logic [CW-1:0]  l;
        logic [CW-1:0]  m;
        hu = ({1'b0, dq_quo[0]} + QW1'(1)) >> 1;
        hv = ({1'b0, dq_quo[1]} + QW1'(1)) >> 1;
        l  = CW'(hu - QW1'(FX_ONE));
        m  = CW'(hv - QW1'(FX_ONE));
        c_bad_next = 1'b0;
        unique case (dq_face)
            cfsp_pkg::FACE_FRONT:  c_p_next = {-l, m, FX_ONE};
            cfsp_pkg::FACE_BACK:   c_p_next = {l, m, -FX_ONE};
            cfsp_pkg::FACE_TOP:    c_p_next = {-m, FX_ONE, l};
            cfsp_pkg::FACE_BOTTOM: c_p_next = {m, -FX_ONE, l};
            cfsp_pkg::FACE_RIGHT:  c_p_next = {FX_ONE, m, l};
            cfsp_pkg::FACE_LEFT:   c_p_next = {-FX_ONE, m, -l};
            default:
            begin
                c_p_next   = '0;
                c_bad_next = 1'b1;
            end
        endcase
    end

    logic                  c_vld_reg;
    logic                  c_bad_reg;
    logic [AX-1:0][CW-1:0] c_p_reg;

    always_ff @(posedge clk)
    begin
        c_bad_reg <= c_bad_next;
        c_p_reg   <= c_p_next;
    end

    // stage d: sign and magnitude
    cfsp_pkg::point_tag_t d_tag_next;

    always_comb
    begin
        d_tag_next.bad = c_bad_reg;
        for (int a = 0; a < AX; a++)
        begin
            d_tag_next.neg[a] = c_p_reg[a][CW-1];
            d_tag_next.mag[a] = c_p_reg[a][CW-1] ? MW'(~c_p_reg[a] + CW'(1)) : MW'(c_p_reg[a]);
        end
    end

    logic                 d_vld_reg;
    cfsp_pkg::point_tag_t d_tag_reg;

    always_ff @(posedge clk)
    begin
        d_tag_reg <= d_tag_next;
    end

    // stage e: squares
    logic                  e_vld_reg;
    cfsp_pkg::point_tag_t  e_tag_reg;
    logic [AX-1:0][MW-1:0] e_sq_reg;

    always_ff @(posedge clk)
    begin
        e_tag_reg <= d_tag_reg;
        for (int a = 0; a < AX; a++)
        begin
            e_sq_reg[a] <= fx_mul(d_tag_reg.mag[a], d_tag_reg.mag[a]);
        end
    end

    // stage f: cross products and sums of the other two squares
    logic                  f_vld_reg;
    cfsp_pkg::point_tag_t  f_tag_reg;
    logic [AX-1:0][MW-1:0] f_ab_reg;
    logic [AX-1:0][MW:0]   f_sum_reg;

    always_ff @(posedge clk)
    begin
        f_tag_reg    <= e_tag_reg;
        f_ab_reg[0]  <= fx_mul(e_sq_reg[1], e_sq_reg[2]);
        f_ab_reg[1]  <= fx_mul(e_sq_reg[2], e_sq_reg[0]);
        f_ab_reg[2]  <= fx_mul(e_sq_reg[0], e_sq_reg[1]);
        f_sum_reg[0] <= (MW + 1)'(e_sq_reg[1]) + (MW + 1)'(e_sq_reg[2]);
        f_sum_reg[1] <= (MW + 1)'(e_sq_reg[2]) + (MW + 1)'(e_sq_reg[0]);
        f_sum_reg[2] <= (MW + 1)'(e_sq_reg[0]) + (MW + 1)'(e_sq_reg[1]);
    end

    // stage g: six times the radicand, halved
    logic [AX-1:0][cfsp_pkg::Y_W-1:0] g_y_next;

    always_comb
    begin
        logic [cfsp_pkg::SIX_W-1:0] six;
        logic [cfsp_pkg::SIX_W-1:0] s3;
        for (int a = 0; a < AX; a++)
        begin
            s3  = cfsp_pkg::SIX_W'(f_sum_reg[a]) + (cfsp_pkg::SIX_W'(f_sum_reg[a]) << 1);
            six = (cfsp_pkg::SIX_W'(6) << cfsp_pkg::FRAC_W)
                + (cfsp_pkg::SIX_W'(f_ab_reg[a]) << 1) - s3;
            g_y_next[a] = cfsp_pkg::Y_W'((six + cfsp_pkg::SIX_W'(3)) >> 1);
        end
    end

    logic                             g_vld_reg;
    cfsp_pkg::point_tag_t             g_tag_reg;
    logic [AX-1:0][cfsp_pkg::Y_W-1:0] g_y_reg;

    always_ff @(posedge clk)
    begin
        g_tag_reg <= f_tag_reg;
        g_y_reg   <= g_y_next;
    end

    // stage h: divide by three through the reciprocal
    logic                                h_vld_reg;
    cfsp_pkg::point_tag_t                h_tag_reg;
    logic [AX-1:0][cfsp_pkg::PROD_W-1:0] h_prod_reg;
    logic [AX-1:0][cfsp_pkg::RAD_W-1:0]  h_rad;

    always_ff @(posedge clk)
    begin
        h_tag_reg <= g_tag_reg;
        for (int a = 0; a < AX; a++)
        begin
            h_prod_reg[a] <= cfsp_pkg::PROD_W'(g_y_reg[a]) * cfsp_pkg::PROD_W'(cfsp_pkg::RECIP_3);
        end
    end

    always_comb
    begin
        for (int a = 0; a < AX; a++)
        begin
            h_rad[a] = cfsp_pkg::RAD_W'(h_prod_reg[a][cfsp_pkg::PROD_W-1:cfsp_pkg::RECIP_SHIFT])
                     << cfsp_pkg::FRAC_W;
        end
    end

    logic                                sq_vld;
    logic [AX-1:0][cfsp_pkg::ROOT_W-1:0] sq_root;
    cfsp_pkg::point_tag_t                sq_tag;

    cfsp_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (h_vld_reg),
        .in_rad    (h_rad),
        .in_tag    (h_tag_reg),
        .out_valid (sq_vld),
        .out_root  (sq_root),
        .out_tag   (sq_tag)
    );

    // stage j: coordinate times spherify factor
    logic                   j_vld_reg;
    cfsp_pkg::point_tag_t   j_tag_reg;
    logic [AX-1:0][PW2-1:0] j_prod_reg;

    always_ff @(posedge clk)
    begin
        j_tag_reg <= sq_tag;
        for (int a = 0; a < AX; a++)
        begin
            j_prod_reg[a] <= PW2'(sq_tag.mag[a]) * PW2'(sq_root[a]);
        end
    end

    // stage k: round, restore sign, output register
    logic [AX-1:0][CW-1:0] k_out_next;

    always_comb
    begin
        logic [CW-1:0] ext;
        for (int a = 0; a < AX; a++)
        begin
            ext = CW'(MW'((j_prod_reg[a] + RND_HALF) >> cfsp_pkg::FRAC_W));
            if (j_tag_reg.bad)
                k_out_next[a] = '0;
            else if (j_tag_reg.neg[a])
                k_out_next[a] = ~ext + CW'(1);
            else
                k_out_next[a] = ext;
        end
    end

    logic                  k_vld_reg;
    logic [AX-1:0][CW-1:0] k_out_reg;

    always_ff @(posedge clk)
    begin
        k_out_reg <= k_out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
            f_vld_reg <= 1'b0;
            g_vld_reg <= 1'b0;
            h_vld_reg <= 1'b0;
            j_vld_reg <= 1'b0;
            k_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= start && !busy;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= dq_vld;
            d_vld_reg <= c_vld_reg;
            e_vld_reg <= d_vld_reg;
            f_vld_reg <= e_vld_reg;
            g_vld_reg <= f_vld_reg;
            h_vld_reg <= g_vld_reg;
            j_vld_reg <= sq_vld;
            k_vld_reg <= j_vld_reg;
        end
    end

    assign done     = k_vld_reg;
    assign sphere_x = k_out_reg[0];
    assign sphere_y = k_out_reg[1];
    assign sphere_z = k_out_reg[2];

endmodule

// ===== design/cfsp_div.sv =====
// pipelined restoring divider, two numerators over one shared denominator
// depends on cfsp_pkg
module cfsp_div (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             in_valid,
    input  logic [cfsp_pkg::UV-1:0][cfsp_pkg::DEN_W-1:0]     in_num,
    input  logic [cfsp_pkg::DEN_W-1:0]                       in_den,
    input  logic [cfsp_pkg::FACE_W-1:0]                      in_face,
    output logic                                             out_valid,
    output logic [cfsp_pkg::UV-1:0][cfsp_pkg::QUO_W-1:0]     out_quo,
    output logic [cfsp_pkg::FACE_W-1:0]                      out_face
);

    localparam int NST   = cfsp_pkg::DIV_STAGES;
    localparam int PER   = cfsp_pkg::DIV_PER_STAGE;
    localparam int REM_W = cfsp_pkg::DEN_W + 1;

    logic [NST-1:0]                                     vld_reg;
    logic [cfsp_pkg::DEN_W-1:0]                         den_reg  [NST];
    logic [cfsp_pkg::DEN_W-1:0]                         den_next [NST];
    logic [cfsp_pkg::FACE_W-1:0]                        face_reg [NST];
    logic [cfsp_pkg::FACE_W-1:0]                        face_next[NST];
    logic [cfsp_pkg::UV-1:0][REM_W-1:0]                 rem_reg  [NST];
    logic [cfsp_pkg::UV-1:0][REM_W-1:0]                 rem_next [NST];
    logic [cfsp_pkg::UV-1:0][cfsp_pkg::QUO_W-1:0]       quo_reg  [NST];
    logic [cfsp_pkg::UV-1:0][cfsp_pkg::QUO_W-1:0]       quo_next [NST];

    always_comb
    begin
        logic [cfsp_pkg::DEN_W-1:0] dv;
        logic [REM_W-1:0]           rem;
        logic [cfsp_pkg::QUO_W-1:0] quo;
        dv  = '0;
        rem = '0;
        quo = '0;
        for (int s = 0; s < NST; s++)
        begin
            if (s == 0)
            begin
                dv           = in_den;
                face_next[s] = in_face;
            end
            else
            begin
                dv           = den_reg[(s > 0) ? s - 1 : 0];
                face_next[s] = face_reg[(s > 0) ? s - 1 : 0];
            end
            den_next[s] = dv;
            for (int ln = 0; ln < cfsp_pkg::UV; ln++)
            begin
                if (s == 0)
                begin
                    rem = REM_W'(in_num[ln]);
                    quo = '0;
                end
                else
                begin
                    rem = rem_reg[(s > 0) ? s - 1 : 0][ln];
                    quo = quo_reg[(s > 0) ? s - 1 : 0][ln];
                end
                for (int k = 0; k < PER; k++)
                begin
                    if (s * PER + k < cfsp_pkg::QUO_W)
                    begin
                        rem = rem << 1;
                        quo = quo << 1;
                        if (rem >= REM_W'(dv))
                        begin
                            rem    = rem - REM_W'(dv);
                            quo[0] = 1'b1;
                        end
                    end
                end
                rem_next[s][ln] = rem;
                quo_next[s][ln] = quo;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= (vld_reg << 1) | NST'(in_valid);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < NST; s++)
        begin
            den_reg[s]  <= den_next[s];
            face_reg[s] <= face_next[s];
            rem_reg[s]  <= rem_next[s];
            quo_reg[s]  <= quo_next[s];
        end
    end

    assign out_valid = vld_reg[NST-1];
    assign out_quo   = quo_reg[NST-1];
    assign out_face  = face_reg[NST-1];

endmodule

// ===== design/cfsp_sqrt.sv =====
// pipelined digit-by-digit integer square root, three lanes in lockstep
// depends on cfsp_pkg
module cfsp_sqrt (
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  logic                                                in_valid,
    input  logic [cfsp_pkg::AXES-1:0][cfsp_pkg::RAD_W-1:0]      in_rad,
    input  cfsp_pkg::point_tag_t                                in_tag,
    output logic                                                out_valid,
    output logic [cfsp_pkg::AXES-1:0][cfsp_pkg::ROOT_W-1:0]     out_root,
    output cfsp_pkg::point_tag_t                                out_tag
);

    localparam int NST   = cfsp_pkg::SQRT_STAGES;
    localparam int PER   = cfsp_pkg::SQRT_PER_STAGE;
    localparam int REM_W = cfsp_pkg::ROOT_W + 4;

    logic [NST-1:0]                                         vld_reg;
    cfsp_pkg::point_tag_t                                   tag_reg  [NST];
    cfsp_pkg::point_tag_t                                   tag_next [NST];
    logic [cfsp_pkg::AXES-1:0][cfsp_pkg::RAD_W-1:0]         rad_reg  [NST];
    logic [cfsp_pkg::AXES-1:0][cfsp_pkg::RAD_W-1:0]         rad_next [NST];
    logic [cfsp_pkg::AXES-1:0][REM_W-1:0]                   rem_reg  [NST];
    logic [cfsp_pkg::AXES-1:0][REM_W-1:0]                   rem_next [NST];
    logic [cfsp_pkg::AXES-1:0][cfsp_pkg::ROOT_W-1:0]        root_reg [NST];
    logic [cfsp_pkg::AXES-1:0][cfsp_pkg::ROOT_W-1:0]        root_next[NST];

    always_comb
    begin
        logic [cfsp_pkg::RAD_W-1:0]  rad;
        logic [REM_W-1:0]            rem;
        logic [cfsp_pkg::ROOT_W-1:0] root;
        logic [REM_W-1:0]            trial;
        rad   = '0;
        rem   = '0;
        root  = '0;
        trial = '0;
        for (int s = 0; s < NST; s++)
        begin
            if (s == 0)
            begin
                tag_next[s] = in_tag;
            end
            else
            begin
                tag_next[s] = tag_reg[(s > 0) ? s - 1 : 0];
            end
            for (int a = 0; a < cfsp_pkg::AXES; a++)
            begin
                if (s == 0)
                begin
                    rad  = in_rad[a];
                    rem  = '0;
                    root = '0;
                end
                else
                begin
                    rad  = rad_reg[(s > 0) ? s - 1 : 0][a];
                    rem  = rem_reg[(s > 0) ? s - 1 : 0][a];
                    root = root_reg[(s > 0) ? s - 1 : 0][a];
                end
                for (int k = 0; k < PER; k++)
                begin
                    if (s * PER + k < cfsp_pkg::ROOT_W)
                    begin
                        rem   = {rem[REM_W-3:0], rad[cfsp_pkg::RAD_W-1 -: 2]};
                        rad   = rad << 2;
                        trial = REM_W'({root, 2'b01});
                        if (rem >= trial)
                        begin
                            rem  = rem - trial;
                            root = {root[cfsp_pkg::ROOT_W-2:0], 1'b1};
                        end
                        else
                        begin
                            root = {root[cfsp_pkg::ROOT_W-2:0], 1'b0};
                        end
                    end
                end
                rad_next[s][a]  = rad;
                rem_next[s][a]  = rem;
                root_next[s][a] = root;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= (vld_reg << 1) | NST'(in_valid);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < NST; s++)
        begin
            tag_reg[s]  <= tag_next[s];
            rad_reg[s]  <= rad_next[s];
            rem_reg[s]  <= rem_next[s];
            root_reg[s] <= root_next[s];
        end
    end

    assign out_valid = vld_reg[NST-1];
    assign out_root  = root_reg[NST-1];
    assign out_tag   = tag_reg[NST-1];

endmodule

// ===== design/cfsp_checker.sv =====
// port-level checks for the cube face to sphere point core, bound to the top level
// depends on cfsp_pkg and cube_face_to_sphere_point_core_macros.svh
`include "cube_face_to_sphere_point_core_macros.svh"

module cfsp_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                start,
    input logic                                busy,
    input logic                                cfg_ready,
    input logic                                done,
    input logic signed [cfsp_pkg::COORD_W-1:0] sphere_x,
    input logic signed [cfsp_pkg::COORD_W-1:0] sphere_y,
    input logic signed [cfsp_pkg::COORD_W-1:0] sphere_z
);

    localparam logic signed [cfsp_pkg::COORD_W-1:0] LIM = 32'sd1073741824;

    logic in_range;

    assign in_range = (sphere_x <= LIM) && (sphere_x >= -LIM)
                   && (sphere_y <= LIM) && (sphere_y >= -LIM)
                   && (sphere_z <= LIM) && (sphere_z >= -LIM);

    `CFSP_ASSERT_ALWAYS(a_never_busy, clk, rst_n, !busy && cfg_ready)
    `CFSP_ASSERT_IMPLY(a_start_to_done, clk, rst_n, start, ##(cfsp_pkg::LATENCY) done)
    `CFSP_ASSERT_IMPLY(a_done_from_start, clk, rst_n, done, $past(start, cfsp_pkg::LATENCY))
    `CFSP_ASSERT_IMPLY(a_unit_range, clk, rst_n, done, in_range)

endmodule

bind cube_face_to_sphere_point_core cfsp_checker u_cfsp_checker (.*);
